### rtl/led_matrix_text_scroller_assert.svh
// Assertion helpers for the LED matrix scroller checker.
`ifndef LED_MATRIX_TEXT_SCROLLER_ASSERT_SVH
`define LED_MATRIX_TEXT_SCROLLER_ASSERT_SVH

// Consequent in the same cycle.
`define LMTS_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("lmts assertion failed");

// Consequent in the next cycle.
`define LMTS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("lmts assertion failed");

`endif

### rtl/lmts_pkg.sv
`timescale 1ns / 1ps
package lmts_pkg;

    localparam int MATRIX_SIZE  = 5;
    localparam int FONT_ENTRIES = 26;
    localparam int FONT_LEN     = 26;
    localparam logic [10:0] PORT_BASE = 11'h01f;

    typedef enum logic [1:0] {
        OP_LOAD   = 2'd0,
        OP_SCROLL = 2'd1,
        OP_SCAN   = 2'd2
    } t_op;

    typedef logic [4:0] t_row;

    typedef struct packed {
        logic [2:0]      width;
        logic [4:0][4:0] cols;
    } t_glyph;

    typedef struct packed {
        logic       load;
        logic       scroll_start;
        logic       shift;
        logic       blank;
        logic [2:0] col_idx;
        logic       scan;
        logic       emit;
        logic       last;
    } t_cmd;

    typedef struct packed {
        logic       slot_free;
        logic [2:0] glyph_w;
    } t_sts;

    function automatic t_glyph mk_glyph(input logic [2:0] w, input logic [4:0] c0,
                                        input logic [4:0] c1, input logic [4:0] c2,
                                        input logic [4:0] c3, input logic [4:0] c4);
        t_glyph g;
        g.width   = w;
        g.cols[0] = c0;
        g.cols[1] = c1;
        g.cols[2] = c2;
        g.cols[3] = c3;
        g.cols[4] = c4;
        return g;
    endfunction

    function automatic t_glyph font_glyph(input logic [4:0] code);
        t_glyph g;
        g = '0;
        if (32'(code) < FONT_ENTRIES && 32'(code) < FONT_LEN) begin
            unique case (code)
                5'd0:  g = mk_glyph(3'd3, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00);
                5'd1:  g = mk_glyph(3'd4, 5'h1f, 5'h04, 5'h04, 5'h1f, 5'h00);
                5'd2:  g = mk_glyph(3'd3, 5'h17, 5'h15, 5'h0f, 5'h00, 5'h00);
                5'd3:  g = mk_glyph(3'd4, 5'h1f, 5'h14, 5'h14, 5'h08, 5'h00);
                5'd4:  g = mk_glyph(3'd4, 5'h19, 5'h05, 5'h05, 5'h1e, 5'h00);
                5'd5:  g = mk_glyph(3'd4, 5'h0e, 5'h11, 5'h11, 5'h0a, 5'h00);
                5'd6:  g = mk_glyph(3'd4, 5'h1f, 5'h04, 5'h0c, 5'h13, 5'h00);
                5'd7:  g = mk_glyph(3'd3, 5'h11, 5'h1f, 5'h11, 5'h00, 5'h00);
                5'd8:  g = mk_glyph(3'd4, 5'h1f, 5'h08, 5'h06, 5'h1f, 5'h00);
                5'd9:  g = mk_glyph(3'd4, 5'h0e, 5'h11, 5'h15, 5'h07, 5'h00);
                5'd10: g = mk_glyph(3'd2, 5'h1d, 5'h1c, 5'h00, 5'h00, 5'h00);
                5'd11: g = mk_glyph(3'd5, 5'h1e, 5'h01, 5'h0e, 5'h01, 5'h1e);
                5'd12: g = mk_glyph(3'd3, 5'h1f, 5'h04, 5'h07, 5'h00, 5'h00);
                5'd13: g = mk_glyph(3'd4, 5'h08, 5'h1e, 5'h09, 5'h09, 5'h00);
                5'd14: g = mk_glyph(3'd3, 5'h04, 5'h18, 5'h18, 5'h00, 5'h00);
                5'd15: g = mk_glyph(3'd4, 5'h09, 5'h15, 5'h15, 5'h12, 5'h00);
                5'd16: g = mk_glyph(3'd4, 5'h1e, 5'h01, 5'h01, 5'h1e, 5'h00);
                5'd17: g = mk_glyph(3'd4, 5'h08, 5'h10, 5'h15, 5'h08, 5'h00);
                5'd18: g = mk_glyph(3'd4, 5'h06, 5'h09, 5'h09, 5'h06, 5'h00);
                5'd19: g = mk_glyph(3'd5, 5'h11, 5'h0a, 5'h04, 5'h0a, 5'h11);
                5'd20: g = mk_glyph(3'd4, 5'h1f, 5'h11, 5'h11, 5'h0e, 5'h00);
                5'd21: g = mk_glyph(3'd4, 5'h0e, 5'h15, 5'h15, 5'h0d, 5'h00);
                5'd22: g = mk_glyph(3'd4, 5'h1f, 5'h05, 5'h05, 5'h06, 5'h00);
                5'd23: g = mk_glyph(3'd1, 5'h17, 5'h00, 5'h00, 5'h00, 5'h00);
                5'd24: g = mk_glyph(3'd4, 5'h02, 5'h15, 5'h15, 5'h0f, 5'h00);
                5'd25: g = mk_glyph(3'd4, 5'h0f, 5'h08, 5'h08, 5'h0f, 5'h00);
                default: g = '0;
            endcase
        end
        return g;
    endfunction

endpackage

### rtl/lmts_if.sv
`timescale 1ns / 1ps
interface lmts_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  op;
    logic [24:0] frame_data;
    logic [4:0]  char_code;
    logic [2:0]  column;

    modport source (output valid, op, frame_data, char_code, column, input ready);
    modport sink   (input valid, op, frame_data, char_code, column, output ready);
endinterface

interface lmts_out_if;
    logic        valid;
    logic        ready;
    logic [24:0] frame;
    logic [10:0] port_data;
    logic [4:0]  column_mask;
    logic        last;

    modport source (output valid, frame, port_data, column_mask, last, input ready);
    modport sink   (input valid, frame, port_data, column_mask, last, output ready);
endinterface

### rtl/led_matrix_text_scroller.sv
// Load and scan: the result is registered at the transfer; a new item can be taken while it drains.
// Scroll: the transfer latches the glyph columns and enters the scroll state, which shifts the row
//   registers once per cycle while the output register is free or draining, emitting width plus one frames.
// Input is taken while the controller is idle and the output register is free or draining.
// Reset (synchronous, active low) clears the pixel rows, the controller and output valid.
`timescale 1ns / 1ps
module led_matrix_text_scroller (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lmts_in_if.sink     i_req,
    lmts_out_if.source  o_rsp
);

    lmts_pkg::t_cmd cmd;
    lmts_pkg::t_sts sts;
    logic           ready;

    assign i_req.ready = ready;

    lmts_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_req.valid),
        .i_op    (i_req.op),
        .i_sts   (sts),
        .o_ready (ready),
        .o_cmd   (cmd)
    );

    lmts_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_frame_data  (i_req.frame_data),
        .i_char_code   (i_req.char_code),
        .i_column      (i_req.column),
        .i_out_ready   (o_rsp.ready),
        .o_sts         (sts),
        .o_out_valid   (o_rsp.valid),
        .o_frame       (o_rsp.frame),
        .o_port_data   (o_rsp.port_data),
        .o_column_mask (o_rsp.column_mask),
        .o_last        (o_rsp.last)
    );

endmodule

### rtl/lmts_ctrl.sv
`timescale 1ns / 1ps
module lmts_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic [1:0]      i_op,
    input  lmts_pkg::t_sts  i_sts,
    output logic            o_ready,
    output lmts_pkg::t_cmd  o_cmd
);

    typedef enum logic [1:0] {
        ST_IDLE   = 2'b01,
        ST_SCROLL = 2'b10
    } t_state;

    t_state     r_state, n_state;
    logic [2:0] r_col, n_col;
    logic [2:0] r_width, n_width;
    logic       accept;

    assign o_ready = (r_state == ST_IDLE) && i_sts.slot_free;
    assign accept  = i_valid && o_ready;

    always_comb begin
        n_state = r_state;
        n_col   = r_col;
        n_width = r_width;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    case (i_op)
                        lmts_pkg::OP_LOAD: begin
                            o_cmd.load = 1'b1;
                            o_cmd.emit = 1'b1;
                            o_cmd.last = 1'b1;
                        end
                        lmts_pkg::OP_SCAN: begin
                            o_cmd.scan = 1'b1;
                            o_cmd.emit = 1'b1;
                            o_cmd.last = 1'b1;
                        end
                        lmts_pkg::OP_SCROLL: begin
                            o_cmd.scroll_start = 1'b1;
                            n_width = i_sts.glyph_w;
                            n_col   = '0;
                            n_state = ST_SCROLL;
                        end
                        default: ;
                    endcase
                end
            end
            ST_SCROLL: begin
                if (i_sts.slot_free) begin
                    o_cmd.shift   = 1'b1;
                    o_cmd.emit    = 1'b1;
                    o_cmd.col_idx = r_col;
                    o_cmd.blank   = (r_col >= r_width);
                    o_cmd.last    = (r_col >= r_width);
                    if (r_col >= r_width) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_col = r_col + 3'd1;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_col   <= '0;
            r_width <= '0;
        end else begin
            r_state <= n_state;
            r_col   <= n_col;
            r_width <= n_width;
        end
    end

endmodule

### rtl/lmts_dp.sv
`timescale 1ns / 1ps
module lmts_dp (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  lmts_pkg::t_cmd  i_cmd,
    input  logic [24:0]     i_frame_data,
    input  logic [4:0]      i_char_code,
    input  logic [2:0]      i_column,
    input  logic            i_out_ready,
    output lmts_pkg::t_sts  o_sts,
    output logic            o_out_valid,
    output logic [24:0]     o_frame,
    output logic [10:0]     o_port_data,
    output logic [4:0]      o_column_mask,
    output logic            o_last
);

    lmts_pkg::t_row  r_rows [lmts_pkg::MATRIX_SIZE];
    lmts_pkg::t_row  n_rows [lmts_pkg::MATRIX_SIZE];
    logic [4:0][4:0] r_cols;
    logic            r_out_valid;
    logic [24:0]     r_frame, n_frame;
    logic [10:0]     r_port, n_port;
    logic [4:0]      r_mask, n_mask;
    logic            r_last;
    logic [4:0]      col_bits;
    lmts_pkg::t_glyph glyph;

    assign glyph           = lmts_pkg::font_glyph(i_char_code);
    assign o_sts.slot_free = !r_out_valid || i_out_ready;
    assign o_sts.glyph_w   = glyph.width;

    always_comb begin
        col_bits = '0;
        if (!i_cmd.blank && i_cmd.col_idx < 3'(lmts_pkg::MATRIX_SIZE)) begin
            col_bits = r_cols[i_cmd.col_idx];
        end
        for (int k = 0; k < lmts_pkg::MATRIX_SIZE; k++) begin
            n_rows[k] = r_rows[k];
            if (i_cmd.load) begin
                n_rows[k] = i_frame_data[5*k +: 5];
            end else if (i_cmd.shift) begin
                n_rows[k] = {r_rows[k][3:0], col_bits[k]};
            end
        end
        n_frame = '0;
        for (int k = 0; k < lmts_pkg::MATRIX_SIZE; k++) begin
            n_frame[5*k +: 5] = n_rows[k];
        end
        n_port = '0;
        n_mask = '0;
        if (i_cmd.scan) begin
            n_port = lmts_pkg::PORT_BASE;
            if (i_column < 3'(lmts_pkg::MATRIX_SIZE)) begin
                n_port[5]  = r_rows[0][i_column];
                n_port[6]  = r_rows[1][i_column];
                n_port[7]  = r_rows[2][i_column];
                n_port[9]  = r_rows[3][i_column];
                n_port[10] = r_rows[4][i_column];
                n_mask     = 5'd1 << i_column;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < lmts_pkg::MATRIX_SIZE; k++) begin
                r_rows[k] <= '0;
            end
            r_out_valid <= 1'b0;
        end else begin
            for (int k = 0; k < lmts_pkg::MATRIX_SIZE; k++) begin
                r_rows[k] <= n_rows[k];
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scroll_start) begin
            r_cols <= glyph.cols;
        end
        if (i_cmd.emit) begin
            r_frame <= n_frame;
            r_port  <= n_port;
            r_mask  <= n_mask;
            r_last  <= i_cmd.last;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_frame       = r_frame;
    assign o_port_data   = r_port;
    assign o_column_mask = r_mask;
    assign o_last        = r_last;

endmodule

### rtl/lmts_checker.sv
`timescale 1ns / 1ps
`include "led_matrix_text_scroller_assert.svh"
module lmts_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic [1:0]  i_op,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [10:0] i_port_data,
    input logic [4:0]  i_column_mask,
    input logic        i_last
);

    logic scan_rsp;

    assign scan_rsp = i_out_valid && (i_column_mask != 5'd0);

    `LMTS_ASSERT_NEXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid)
    `LMTS_ASSERT_SAME(a_scan_single, scan_rsp, i_last)
    `LMTS_ASSERT_SAME(a_scan_port, scan_rsp, $onehot(i_column_mask) && (i_port_data[4:0] == 5'h1f))
    `LMTS_ASSERT_NEXT(a_scroll_busy, i_in_valid && i_in_ready && (i_op == lmts_pkg::OP_SCROLL), !i_in_ready)

endmodule

bind led_matrix_text_scroller lmts_checker u_lmts_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_req.valid),
    .i_in_ready    (i_req.ready),
    .i_op          (i_req.op),
    .i_out_valid   (o_rsp.valid),
    .i_out_ready   (o_rsp.ready),
    .i_port_data   (o_rsp.port_data),
    .i_column_mask (o_rsp.column_mask),
    .i_last        (o_rsp.last)
);
